### design/csd_pkg.sv
`default_nettype none
package csd_pkg;

    localparam int unsigned TICK_W = 32;
    localparam int unsigned CFG_W  = 32;

    // Sequence timing in ticks, repeat limits, and current and voltage thresholds
    localparam logic [TICK_W-1:0] STOP_PERIOD  = 32'd10;
    localparam logic [5:0]        STOP_MAX     = 6'd50;
    localparam logic [TICK_W-1:0] ERR_PERIOD   = 32'd250;
    localparam logic [2:0]        ERR_MAX      = 3'd5;
    localparam logic [TICK_W-1:0] V2L_PERIOD   = 32'd100;
    localparam logic [TICK_W-1:0] CUR_WAIT     = 32'd120;
    localparam logic [TICK_W-1:0] DRAIN_WAIT   = 32'd4000;
    localparam logic [15:0]       CUR_LOW      = 16'd50;
    localparam logic [15:0]       VOLT_LOW     = 16'd600;

    // Register reset values
    localparam logic [15:0] CC_DEBOUNCE_RST = 16'd100;
    localparam logic [31:0] SLEEP_RST       = 32'd60000;
    localparam logic [11:0] VIN_THRESH_RST  = 12'd1000;
    localparam logic        V2L_EN_RST      = 1'b0;

    typedef enum logic [1:0] {
        REG_CC_DEBOUNCE = 2'd0,
        REG_SLEEP       = 2'd1,
        REG_VIN_THRESH  = 2'd2,
        REG_V2L_EN      = 2'd3
    } csd_reg_idx_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_POLL  = 1'b1
    } csd_op_t;

    typedef struct packed {
        logic [15:0] cc_debounce_ticks;
        logic [31:0] sleep_timeout_ticks;
        logic [11:0] vin_valid_threshold;
        logic        v2l_enabled;
    } csd_cfg_t;

    typedef struct packed {
        logic        op;
        logic [31:0] now_tick;
        logic [15:0] module_current;
        logic [15:0] module_voltage;
        logic        cc_connected;
        logic [11:0] vin_sample;
        logic        cem_fault_pending;
        logic [31:0] v2l_start_tick;
    } csd_item_t;

    typedef struct packed {
        logic send_stop_msg;
        logic send_error_msg;
        logic send_v2l_msg;
        logic battery_power_on;
        logic output_open;
        logic module_stop;
        logic lock_engaged;
        logic turn_off_request;
    } csd_result_t;

    typedef struct packed {
        logic [TICK_W-1:0] stop_timer;
        logic              stop_active;
        logic [5:0]        stop_count;
        logic [TICK_W-1:0] error_timer;
        logic              error_active;
        logic [2:0]        error_count;
        logic [TICK_W-1:0] v2l_timer;
        logic              v2l_active;
        logic [TICK_W-1:0] current_wait_timer;
        logic              current_wait_active;
        logic [TICK_W-1:0] drain_timer;
        logic              drain_active;
        logic [TICK_W-1:0] debounce_timer;
        logic              debounce_active;
        logic [TICK_W-1:0] sleep_timer;
        logic              sleep_active;
        logic              seq_end;
        logic              gunout;
        logic              bms;
        logic              lock;
        logic              running;
    } csd_state_t;

endpackage
`default_nettype wire

### design/csd_item_if.sv
`default_nettype none
interface csd_item_if;
    import csd_pkg::*;

    logic      valid;
    logic      ready;
    csd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/csd_result_if.sv
`default_nettype none
interface csd_result_if;
    import csd_pkg::*;

    logic        valid;
    logic        ready;
    csd_result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/csd_cfg.sv
`default_nettype none
module csd_cfg (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [csd_pkg::CFG_W-1:0] cfg_data,
    output csd_pkg::csd_cfg_t              cfg
);
    import csd_pkg::*;

    csd_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cc_debounce_ticks   <= CC_DEBOUNCE_RST;
            cfg_reg.sleep_timeout_ticks <= SLEEP_RST;
            cfg_reg.vin_valid_threshold <= VIN_THRESH_RST;
            cfg_reg.v2l_enabled         <= V2L_EN_RST;
        end
        else if (cfg_we)
        begin
            unique case (csd_reg_idx_t'(cfg_index))
                REG_CC_DEBOUNCE: cfg_reg.cc_debounce_ticks   <= cfg_data[15:0];
                REG_SLEEP:       cfg_reg.sleep_timeout_ticks <= cfg_data;
                REG_VIN_THRESH:  cfg_reg.vin_valid_threshold <= cfg_data[11:0];
                REG_V2L_EN:      cfg_reg.v2l_enabled         <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;
endmodule
`default_nettype wire

### design/csd_step.sv
`default_nettype none
module csd_step (
    input  wire csd_pkg::csd_cfg_t    cfg,
    input  wire csd_pkg::csd_state_t  st,
    input  wire csd_pkg::csd_item_t   item,
    output csd_pkg::csd_state_t       st_next,
    output csd_pkg::csd_result_t      res
);
    import csd_pkg::*;

    always_comb
    begin
        csd_state_t s;
        logic s_stop, s_err, s_v2l, o_open, m_stop, t_off;
        logic [TICK_W-1:0] now;

        s      = st;
        now    = item.now_tick;
        s_stop = 1'b0;
        s_err  = 1'b0;
        s_v2l  = 1'b0;
        o_open = 1'b0;
        m_stop = 1'b0;
        t_off  = 1'b0;

        if (item.op == OP_START)
        begin
            s.seq_end             = 1'b0;
            s.gunout              = 1'b0;
            s.bms                 = 1'b1;
            s.lock                = 1'b1;
            s.running             = 1'b1;
            m_stop                = 1'b1;
            s_stop                = 1'b1;
            s.stop_timer          = now;
            s.stop_active         = 1'b1;
            s.stop_count          = '0;
            s_err                 = 1'b1;
            s.error_timer         = now;
            s.error_active        = 1'b1;
            s.error_count         = '0;
            s.v2l_timer           = item.v2l_start_tick;
            s.v2l_active          = (item.v2l_start_tick != '0);
            s.current_wait_timer  = now;
            s.current_wait_active = 1'b1;
            s.drain_timer         = '0;
            s.drain_active        = 1'b0;
            s.debounce_timer      = '0;
            s.debounce_active     = 1'b0;
            s.sleep_timer         = '0;
            s.sleep_active        = 1'b0;
        end
        else if (st.running)
        begin
            if (st.stop_active && (now - st.stop_timer) > STOP_PERIOD)
            begin
                s_stop       = 1'b1;
                s.stop_timer = now;
                s.stop_count = st.stop_count + 6'd1;
                if (s.stop_count > STOP_MAX)
                begin
                    s.stop_active = 1'b0;
                    s.v2l_active  = 1'b0;
                end
            end
            if (st.error_active && (now - st.error_timer) > ERR_PERIOD)
            begin
                s_err         = item.cem_fault_pending;
                s.error_timer = now;
                s.error_count = st.error_count + 3'd1;
                if (s.error_count > ERR_MAX)
                begin
                    s.bms          = 1'b0;
                    s.error_active = 1'b0;
                end
            end
            // v2l_active may have just been cleared by the stop step
            if (s.v2l_active && (now - st.v2l_timer) > V2L_PERIOD && cfg.v2l_enabled)
            begin
                s_v2l       = 1'b1;
                s.v2l_timer = now;
            end
            if (st.current_wait_active &&
                (item.module_current < CUR_LOW || (now - st.current_wait_timer) > CUR_WAIT))
            begin
                o_open                = 1'b1;
                s.drain_timer         = now;
                s.drain_active        = 1'b1;
                s.current_wait_active = 1'b0;
            end
            // drain may be armed in this same poll; its elapsed time is then zero
            if (s.drain_active &&
                (item.module_voltage < VOLT_LOW || (now - s.drain_timer) > DRAIN_WAIT))
            begin
                s.seq_end      = 1'b1;
                s.drain_active = 1'b0;
            end
            if (s.seq_end && s.error_count > ERR_MAX)
            begin
                s.lock = 1'b0;
                if (st.gunout && item.vin_sample < cfg.vin_valid_threshold)
                    t_off = 1'b1;
                if (!st.sleep_active)
                begin
                    s.sleep_timer  = now;
                    s.sleep_active = 1'b1;
                end
                else if ((now - st.sleep_timer) > cfg.sleep_timeout_ticks)
                    t_off = 1'b1;
            end
            if (!item.cc_connected)
            begin
                if (!st.debounce_active)
                begin
                    s.debounce_timer  = now;
                    s.debounce_active = 1'b1;
                end
            end
            else
                s.debounce_active = 1'b0;
            if (s.debounce_active &&
                (now - s.debounce_timer) > {16'd0, cfg.cc_debounce_ticks})
            begin
                m_stop            = 1'b1;
                o_open            = 1'b1;
                s.gunout          = 1'b1;
                s.debounce_active = 1'b0;
            end
            if (t_off)
                s.running = 1'b0;
        end

        st_next                  = s;
        res.send_stop_msg        = s_stop;
        res.send_error_msg       = s_err;
        res.send_v2l_msg         = s_v2l;
        res.battery_power_on     = s.bms;
        res.output_open          = o_open;
        res.module_stop          = m_stop;
        res.lock_engaged         = s.lock;
        res.turn_off_request     = t_off;
    end
endmodule
`default_nettype wire

### design/charger_shutdown_sequencer_core.sv
`default_nettype none
// An item waits in the input register; its result loads the result register once that is empty or read.
// Throughput: one item per cycle while result.ready holds no result back; the sequencer state
// updates in the same cycle as the result register loads, so the next item sees it directly.
// Reset (rst_n, async, active low): pipeline empty, sequence idle with power and lock
// off, configuration registers at their defaults.
module charger_shutdown_sequencer_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    csd_item_if.sink                       item,
    csd_result_if.source                   result,
    input  wire logic                      cfg_we,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [csd_pkg::CFG_W-1:0] cfg_data
);
    import csd_pkg::*;

    csd_cfg_t    cfg;
    logic        in_valid_reg;
    csd_item_t   in_data_reg;
    logic        out_valid_reg;
    csd_result_t out_data_reg;
    csd_state_t  st_reg;
    csd_state_t  st_next;
    csd_result_t res;
    logic        advance;

    csd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    csd_step u_step (
        .cfg     (cfg),
        .st      (st_reg),
        .item    (in_data_reg),
        .st_next (st_next),
        .res     (res)
    );

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            if (item.ready)
                in_valid_reg <= item.valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
            in_data_reg <= item.data;
        if (advance)
            out_data_reg <= res;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;
endmodule
`default_nettype wire

### test/tb.sv
module tb;
    import csd_pkg::*;

    localparam int unsigned PHASE_ITEMS = 160;   // items per randomized phase
    localparam int unsigned STALL_LIMIT = 4000;  // cycles with no transfer before giving up
    localparam int unsigned DRAIN_WAIT_CYCLES = 4;

    localparam csd_result_t RES_IDLE  = 8'b0000_0000;
    localparam csd_result_t RES_START = 8'b1101_0110;
    localparam csd_result_t RES_HOLD  = 8'b0001_0010;
    localparam csd_result_t RES_STOP  = 8'b1001_0010;

    typedef struct {
        csd_item_t   it;
        bit          typed;
        csd_result_t res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    csd_item_if   item_ch ();
    csd_result_if res_ch ();

    charger_shutdown_sequencer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    csd_state_t  seq_st;
    csd_cfg_t    seq_cfg;
    csd_result_t pending_outputs [$];
    dir_row_t    dir_tab [$];
    int          idle_pct;
    int          stall_pct;
    int          items_sent;
    int          fail_count;
    int          stall_cycles;

    string field_names [8] = '{"send_stop_msg", "send_error_msg", "send_v2l_msg",
                               "battery_power_on", "output_open", "module_stop",
                               "lock_engaged", "turn_off_request"};

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [31:0] ticks_since(input logic [31:0] now, input logic [31:0] stamp);
        return now - stamp;
    endfunction

    // One item through the shutdown sequence; updates seq_st and returns the outputs.
    function automatic csd_result_t shutdown_step(input csd_item_t it);
        csd_result_t r;
        logic        off_req;
        r = '0;
        off_req = 1'b0;
        if (it.op == OP_START) begin
            seq_st = '0;
            seq_st.bms = 1'b1;
            seq_st.lock = 1'b1;
            seq_st.running = 1'b1;
            r.module_stop = 1'b1;
            r.send_stop_msg = 1'b1;
            r.send_error_msg = 1'b1;
            seq_st.stop_timer = it.now_tick;
            seq_st.stop_active = 1'b1;
            seq_st.error_timer = it.now_tick;
            seq_st.error_active = 1'b1;
            seq_st.v2l_timer = it.v2l_start_tick;
            seq_st.v2l_active = (it.v2l_start_tick != 32'd0);
            seq_st.current_wait_timer = it.now_tick;
            seq_st.current_wait_active = 1'b1;
        end
        else if (seq_st.running) begin
            if (seq_st.stop_active && ticks_since(it.now_tick, seq_st.stop_timer) > STOP_PERIOD)
            begin
                r.send_stop_msg = 1'b1;
                seq_st.stop_timer = it.now_tick;
                seq_st.stop_count = seq_st.stop_count + 6'd1;
                if (seq_st.stop_count > STOP_MAX)
                begin
                    seq_st.stop_active = 1'b0;
                    seq_st.v2l_active = 1'b0;
                end
            end
            if (seq_st.error_active && ticks_since(it.now_tick, seq_st.error_timer) > ERR_PERIOD)
            begin
                // count rises even when no fault is carried
                r.send_error_msg = it.cem_fault_pending;
                seq_st.error_timer = it.now_tick;
                seq_st.error_count = seq_st.error_count + 3'd1;
                if (seq_st.error_count > ERR_MAX)
                begin
                    seq_st.bms = 1'b0;
                    seq_st.error_active = 1'b0;
                end
            end
            if (seq_st.v2l_active && ticks_since(it.now_tick, seq_st.v2l_timer) > V2L_PERIOD
                && seq_cfg.v2l_enabled)
            begin
                r.send_v2l_msg = 1'b1;
                seq_st.v2l_timer = it.now_tick;
            end
            if (seq_st.current_wait_active && (it.module_current < CUR_LOW
                || ticks_since(it.now_tick, seq_st.current_wait_timer) > CUR_WAIT))
            begin
                r.output_open = 1'b1;
                seq_st.drain_timer = it.now_tick;
                seq_st.drain_active = 1'b1;
                seq_st.current_wait_active = 1'b0;
            end
            if (seq_st.drain_active && (it.module_voltage < VOLT_LOW
                || ticks_since(it.now_tick, seq_st.drain_timer) > DRAIN_WAIT))
            begin
                seq_st.seq_end = 1'b1;
                seq_st.drain_active = 1'b0;
            end
            if (seq_st.seq_end && seq_st.error_count > ERR_MAX)
            begin
                seq_st.lock = 1'b0;
                if (seq_st.gunout && it.vin_sample < seq_cfg.vin_valid_threshold)
                    off_req = 1'b1;
                if (!seq_st.sleep_active)
                begin
                    seq_st.sleep_timer = it.now_tick;
                    seq_st.sleep_active = 1'b1;
                end
                else if (ticks_since(it.now_tick, seq_st.sleep_timer)
                         > seq_cfg.sleep_timeout_ticks)
                    off_req = 1'b1;
            end
            if (!it.cc_connected)
            begin
                if (!seq_st.debounce_active)
                begin
                    seq_st.debounce_timer = it.now_tick;
                    seq_st.debounce_active = 1'b1;
                end
            end
            else
                seq_st.debounce_active = 1'b0;
            if (seq_st.debounce_active && ticks_since(it.now_tick, seq_st.debounce_timer)
                > {16'd0, seq_cfg.cc_debounce_ticks})
            begin
                r.module_stop = 1'b1;
                r.output_open = 1'b1;
                seq_st.gunout = 1'b1;
                seq_st.debounce_active = 1'b0;
            end
            if (off_req)
                seq_st.running = 1'b0;
        end
        r.turn_off_request = off_req;
        r.battery_power_on = seq_st.bms;
        r.lock_engaged = seq_st.lock;
        return r;
    endfunction

    function automatic csd_item_t rand_item();
        csd_item_t it;
        it.op = csd_op_t'($urandom_range(1));
        it.now_tick = $urandom();
        it.module_current = 16'($urandom());
        it.module_voltage = 16'($urandom());
        it.cc_connected = 1'($urandom_range(1));
        it.vin_sample = 12'($urandom());
        it.cem_fault_pending = 1'($urandom_range(1));
        it.v2l_start_tick = $urandom();
        return it;
    endfunction

    task automatic add_row(input csd_op_t op, input logic [31:0] now, input logic [15:0] cur,
                           input logic [15:0] volt, input logic cc, input logic [11:0] vin,
                           input logic fault, input logic [31:0] v2l, input bit typed,
                           input csd_result_t res);
        dir_row_t row;
        row.it.op = op;
        row.it.now_tick = now;
        row.it.module_current = cur;
        row.it.module_voltage = volt;
        row.it.cc_connected = cc;
        row.it.vin_sample = vin;
        row.it.cem_fault_pending = fault;
        row.it.v2l_start_tick = v2l;
        row.typed = typed;
        row.res = res;
        dir_tab.push_back(row);
    endtask

    // Called right after a falling edge; returns right after the falling edge that
    // follows the transfer.
    task automatic send_item(input csd_item_t it, input bit typed, input csd_result_t res);
        csd_result_t predicted;
        while ($urandom_range(99) < idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        predicted = shutdown_step(it);
        pending_outputs.push_back(typed ? res : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(input csd_cfg_t c);
        cfg_we <= 1'b1;
        cfg_index <= REG_CC_DEBOUNCE;
        cfg_data <= {16'd0, c.cc_debounce_ticks};
        @(negedge clk);
        cfg_index <= REG_SLEEP;
        cfg_data <= c.sleep_timeout_ticks;
        @(negedge clk);
        cfg_index <= REG_VIN_THRESH;
        cfg_data <= {20'd0, c.vin_valid_threshold};
        @(negedge clk);
        cfg_index <= REG_V2L_EN;
        cfg_data <= {31'd0, c.v2l_enabled};
        @(negedge clk);
        cfg_we <= 1'b0;
        seq_cfg = c;
        @(negedge clk);
    endtask

    // A start followed by polls whose tick advances, so that the sequence can walk
    // through message repeats, current and drain waits, gun removal and turn-off.
    // Stops early once the item count reaches limit.
    task automatic run_sequence(input logic [31:0] limit);
        csd_item_t   it;
        logic [31:0] t;
        int          n_polls;
        int          step_max;
        int          cur_low_at;
        int          drain_at;
        int          cc_loss_at;
        int          after_off;
        it = rand_item();
        t = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(3000) : $urandom();
        it.op = OP_START;
        it.now_tick = t;
        case ($urandom_range(3))
            0: it.v2l_start_tick = 32'd0;
            1: it.v2l_start_tick = t - $urandom_range(200);
            default: it.v2l_start_tick = $urandom();
        endcase
        send_item(it, 1'b0, RES_IDLE);
        n_polls = $urandom_range(30, 110);
        case ($urandom_range(2))
            0: step_max = 12;
            1: step_max = 60;
            default: step_max = 260;
        endcase
        cur_low_at = $urandom_range(0, 60);
        drain_at = $urandom_range(0, 40);
        cc_loss_at = $urandom_range(10, n_polls);
        after_off = 0;
        for (int k = 0; k < n_polls && after_off < 3 && items_sent < limit; k++)
        begin
            if ($urandom_range(29) == 0)
                it = rand_item();
            else
            begin
                t = t + (($urandom_range(14) == 0) ? $urandom_range(5000)
                                                    : $urandom_range(step_max));
                it = rand_item();
                it.op = OP_POLL;
                it.now_tick = t;
                if (k >= cur_low_at && $urandom_range(3) == 0)
                    it.module_current = 16'($urandom_range(49));
                else
                    it.module_current = 16'($urandom_range(50, 65535));
                if (k >= drain_at && $urandom_range(1) == 0)
                    it.module_voltage = 16'($urandom_range(599));
                else
                    it.module_voltage = 16'($urandom_range(600, 65535));
                if (k >= cc_loss_at)
                    it.cc_connected = ($urandom_range(9) == 0);
                else
                    it.cc_connected = ($urandom_range(19) != 0);
            end
            send_item(it, 1'b0, RES_IDLE);
            if (!seq_st.running)
                after_off++;
        end
    endtask

    // Receiver side
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        csd_result_t exp_res;
        logic [7:0]  e;
        logic [7:0]  a;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_outputs.size() == 0)
            begin
                fail_count++;
                $display("%0t: result %b with no transfer outstanding", $realtime, res_ch.data);
            end
            else
            begin
                exp_res = pending_outputs.pop_front();
                e = exp_res;
                a = res_ch.data;
                if (a !== e)
                begin
                    fail_count++;
                    if (fail_count < 40)
                        for (int i = 0; i < 8; i++)
                            if (a[7-i] !== e[7-i])
                                $display("%0t: %s expected %b got %b", $realtime,
                                         field_names[i], e[7-i], a[7-i]);
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[charger_shutdown_sequencer_core] ERROR");
            $finish;
        end
    end

    initial
    begin
        csd_cfg_t c;
        logic [31:0] b;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_CC_DEBOUNCE;
        cfg_data = 32'd0;
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        seq_st = '0;
        seq_cfg.cc_debounce_ticks = CC_DEBOUNCE_RST;
        seq_cfg.sleep_timeout_ticks = SLEEP_RST;
        seq_cfg.vin_valid_threshold = VIN_THRESH_RST;
        seq_cfg.v2l_enabled = V2L_EN_RST;

        b = 32'h0000_1000;
        // polls before any start change nothing
        add_row(OP_POLL, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 12'hFFF, 1'b1,
                32'hFFFF_FFFF, 1'b1, RES_IDLE);
        add_row(OP_POLL, 32'd0, 16'd0, 16'd0, 1'b0, 12'd0, 1'b0, 32'd0, 1'b1, RES_IDLE);
        // start just below the tick wrap, V2L inactive
        add_row(OP_START, 32'hFFFF_FFF0, 16'd0, 16'd0, 1'b0, 12'd0, 1'b0, 32'd0, 1'b1, RES_START);
        add_row(OP_POLL, 32'hFFFF_FFFA, 16'hFFFF, 16'hFFFF, 1'b1, 12'hFFF, 1'b0, 32'd0,
                1'b1, RES_HOLD);
        add_row(OP_POLL, 32'hFFFF_FFFB, 16'hFFFF, 16'hFFFF, 1'b1, 12'hFFF, 1'b0, 32'd0,
                1'b1, RES_STOP);
        // current wait times out across the wrap
        add_row(OP_POLL, 32'h0000_0069, 16'hFFFF, 16'hFFFF, 1'b1, 12'hFFF, 1'b0, 32'd0,
                1'b0, RES_IDLE);
        // restart while running, V2L active
        add_row(OP_START, b, 16'd100, 16'd700, 1'b1, 12'h800, 1'b1, 32'h0000_0F00,
                1'b1, RES_START);
        add_row(OP_POLL, b + 1, 16'd10, 16'd700, 1'b1, 12'h800, 1'b1, 32'd0, 1'b0, RES_IDLE);
        add_row(OP_POLL, b + 2, 16'hFFFF, 16'd599, 1'b1, 12'h800, 1'b1, 32'd0, 1'b0, RES_IDLE);
        // six error repeats, fault alternating; the last drops power and the lock
        for (int k = 1; k <= 6; k++)
            add_row(OP_POLL, b + 251 * k, 16'hFFFF, 16'hFFFF, 1'b1, 12'h800, k[0], 32'd0,
                    1'b0, RES_IDLE);
        // CC lost, debounced into gun removal, then low input requests turn-off
        add_row(OP_POLL, b + 1507, 16'hFFFF, 16'hFFFF, 1'b0, 12'hFFF, 1'b0, 32'd0,
                1'b0, RES_IDLE);
        add_row(OP_POLL, b + 1608, 16'hFFFF, 16'hFFFF, 1'b0, 12'hFFF, 1'b0, 32'd0,
                1'b0, RES_IDLE);
        add_row(OP_POLL, b + 1609, 16'hFFFF, 16'hFFFF, 1'b1, 12'd999, 1'b0, 32'd0,
                1'b0, RES_IDLE);
        // idle again after turn-off
        add_row(OP_POLL, b + 1700, 16'hFFFF, 16'hFFFF, 1'b1, 12'hFFF, 1'b1, 32'hFFFF_FFFF,
                1'b1, RES_IDLE);
        add_row(OP_START, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 12'hFFF, 1'b1,
                32'hFFFF_FFFF, 1'b1, RES_START);
        add_row(OP_POLL, 32'h0000_0064, 16'hFFFF, 16'hFFFF, 1'b1, 12'hFFF, 1'b1, 32'd0,
                1'b0, RES_IDLE);

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].res);

        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                    c = '{16'd0, 32'd0, 12'hFFF, 1'b1};
                end
                1:
                begin
                    idle_pct = 73;
                    stall_pct = 0;
                    c = '{16'hFFFF, 32'hFFFF_FFFF, 12'd0, 1'b0};
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 73;
                    c.cc_debounce_ticks = 16'($urandom_range(400));
                    c.sleep_timeout_ticks = $urandom_range(3000);
                    c.vin_valid_threshold = 12'($urandom());
                    c.v2l_enabled = 1'($urandom_range(1));
                end
                default:
                begin
                    idle_pct = 30;
                    stall_pct = 30;
                    c.cc_debounce_ticks = 16'($urandom_range(400));
                    c.sleep_timeout_ticks = $urandom_range(3000);
                    c.vin_valid_threshold = 12'($urandom());
                    c.v2l_enabled = 1'b1;
                end
            endcase
            write_config(c);
            b = items_sent + PHASE_ITEMS;
            while (items_sent < b)
                run_sequence(b);
        end

        wait_drained();
        if (fail_count == 0 && pending_outputs.size() == 0)
            $display("[charger_shutdown_sequencer_core] OK");
        else
            $display("[charger_shutdown_sequencer_core] ERROR");
        $finish;
    end

endmodule
